@@ rtl/core/bxd_pkg.sv @@
// Box average downscaler: shared types, widths, register codes and reset values.
// No dependencies.
package bxd_pkg;

  localparam int DIM_W      = 12;   // width/height register width
  localparam int SCL_W      = 5;    // scale register width
  localparam int SUM_W      = 16;   // per-component block sum
  localparam int DIV_W      = 2 * SCL_W; // scale squared
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int HGT_LIM    = 2048;
  localparam int Q_DEPTH    = 4;
  localparam int QC_W       = $clog2(Q_DEPTH + 1);

  localparam logic [SCL_W-1:0] RST_SCALE  = SCL_W'(1);
  localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(1920);
  localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(1080);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE    = 2'd0,
    CFG_WIDTH    = 2'd1,
    CFG_HEIGHT   = 2'd2,
    CFG_TWO_COMP = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] sample_first;
    logic [PIX_W-1:0] sample_second;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] average_first;
    logic [PIX_W-1:0] average_second;
    logic             image_last;
  } out_beat_t;

  // Effective (clamped) configuration seen by the datapath.
  typedef struct packed {
    logic [SCL_W-1:0] scale;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             two_comp;
  } cfg_eff_t;

  // Finished block sum handed from front to back.
  typedef struct packed {
    logic             img_last;
    logic [SUM_W-1:0] sum_second;
    logic [SUM_W-1:0] sum_first;
  } blk_sum_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_WAIT
  } bk_state_t;

endpackage

@@ rtl/core/bxd_divu.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; used by bxd_front and bxd_back.
module bxd_divu #(
  parameter int NW = 16,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CW = (NW > 1) ? $clog2(NW) : 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] acc_r, acc_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {acc_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW - 1);
      acc_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      acc_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = acc_r;

endmodule

@@ rtl/core/bxd_fifo.sv @@
// Short queue of finished block sums between front and back.
// Depends on bxd_pkg.
module bxd_fifo import bxd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  blk_sum_t        push_data,
  input  logic            pop,
  output blk_sum_t        head,
  output logic            empty,
  output logic [QC_W-1:0] count
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  blk_sum_t        slot_r [Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;
  logic            do_pop;

  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + QC_W'(1);
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = slot_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

endmodule

@@ rtl/core/bxd_front.sv @@
// Front end: pixel position tracking, line store accumulate, block completion.
// Depends on bxd_pkg and bxd_divu.
module bxd_front import bxd_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_eff_t        cfg,
  input  logic            scale_wr,
  input  logic            in_push,
  output logic            in_full,
  input  in_beat_t        in_data,
  input  logic [QC_W-1:0] q_count,
  output logic            q_push,
  output blk_sum_t        q_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // position state
  logic [DIM_W-1:0] x_r, x_nxt;
  logic [DIM_W-1:0] y_r, y_nxt;
  logic [SCL_W-1:0] cib_r, cib_nxt;
  logic [SCL_W-1:0] rib_r, rib_nxt;
  logic [AW-1:0]    bx_r, bx_nxt;
  logic             pend_r, pend_nxt;

  // resync dividers
  logic             dv_start, dv_busy, dv_done;
  logic [DIM_W-1:0] quo_x;
  logic [SCL_W-1:0] rem_x, rem_y;

  // geometry
  logic [DIM_W-1:0] base_x, base_y;
  logic [DIM_W:0]   end_x, end_y;
  logic [DIM_W+1:0] end2_x, end2_y;
  logic             in_x, in_y, last_x, last_y;
  logic             x_wrap, y_wrap, cib_end, rib_end;
  logic             accept, hit;

  // accumulate stage
  logic                   b_valid_r;
  logic [AW-1:0]          b_addr_r;
  logic                   b_first_r, b_last_r, b_img_r;
  logic [PIX_W-1:0]       b_s1_r, b_s2_r;
  logic                   fwd_r;
  logic [2*SUM_W-1:0]     fwd_data_r;
  logic [2*SUM_W-1:0]     rd_data_r;
  logic [2*SUM_W-1:0]     base_sum;
  logic [SUM_W-1:0]       lo_c, hi_c;
  logic [2*SUM_W-1:0]     line_mem [MAX_WIDTH];

  assign dv_start = pend_r && !dv_busy;
  assign pend_nxt = scale_wr ? 1'b1 : (dv_start ? 1'b0 : pend_r);

  bxd_divu #(.NW(DIM_W), .DW(SCL_W)) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (dv_start),
    .dividend  (x_r),
    .divisor   (cfg.scale),
    .busy      (dv_busy),
    .done      (dv_done),
    .quotient  (quo_x),
    .remainder (rem_x)
  );

  bxd_divu #(.NW(DIM_W), .DW(SCL_W)) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (dv_start),
    .dividend  (y_r),
    .divisor   (cfg.scale),
    .busy      (),
    .done      (),
    .quotient  (),
    .remainder (rem_y)
  );

  assign in_full = pend_r || dv_busy || dv_done || (q_count >= QC_W'(Q_DEPTH - 1));
  assign accept  = in_push && !in_full;

  // block k covers [k*s, (k+1)*s); it is whole when (k+1)*s <= size
  assign base_x = x_r - DIM_W'(cib_r);
  assign base_y = y_r - DIM_W'(rib_r);
  assign end_x  = {1'b0, base_x} + (DIM_W+1)'(cfg.scale);
  assign end_y  = {1'b0, base_y} + (DIM_W+1)'(cfg.scale);
  assign end2_x = {1'b0, end_x} + (DIM_W+2)'(cfg.scale);
  assign end2_y = {1'b0, end_y} + (DIM_W+2)'(cfg.scale);
  assign in_x   = (end_x <= {1'b0, cfg.width});
  assign in_y   = (end_y <= {1'b0, cfg.height});
  assign last_x = (end2_x > {2'b0, cfg.width});
  assign last_y = (end2_y > {2'b0, cfg.height});
  assign hit    = in_x && in_y;

  assign x_wrap  = (({1'b0, x_r} + (DIM_W+1)'(1)) >= {1'b0, cfg.width});
  assign y_wrap  = (({1'b0, y_r} + (DIM_W+1)'(1)) >= {1'b0, cfg.height});
  assign cib_end = (cib_r == cfg.scale - SCL_W'(1));
  assign rib_end = (rib_r == cfg.scale - SCL_W'(1));

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    cib_nxt = cib_r;
    rib_nxt = rib_r;
    bx_nxt  = bx_r;
    if (dv_done) begin
      cib_nxt = rem_x;
      rib_nxt = rem_y;
      bx_nxt  = AW'(quo_x);
    end else if (accept) begin
      if (x_wrap) begin
        x_nxt   = '0;
        cib_nxt = '0;
        bx_nxt  = '0;
        if (y_wrap) begin
          y_nxt   = '0;
          rib_nxt = '0;
        end else begin
          y_nxt   = y_r + DIM_W'(1);
          rib_nxt = rib_end ? '0 : rib_r + SCL_W'(1);
        end
      end else begin
        x_nxt   = x_r + DIM_W'(1);
        cib_nxt = cib_end ? '0 : cib_r + SCL_W'(1);
        bx_nxt  = cib_end ? bx_r + AW'(1) : bx_r;
      end
    end
  end

  // accumulate; forward the value being written when the next pixel hits the same entry
  assign base_sum = fwd_r ? fwd_data_r : rd_data_r;
  assign lo_c = b_first_r ? SUM_W'(b_s1_r) : base_sum[SUM_W-1:0] + SUM_W'(b_s1_r);
  assign hi_c = b_first_r ? SUM_W'(b_s2_r) : base_sum[2*SUM_W-1:SUM_W] + SUM_W'(b_s2_r);

  assign q_push = b_valid_r && b_last_r;
  assign q_data = '{img_last: b_img_r, sum_second: hi_c, sum_first: lo_c};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r       <= '0;
      y_r       <= '0;
      cib_r     <= '0;
      rib_r     <= '0;
      bx_r      <= '0;
      pend_r    <= 1'b0;
      b_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      cib_r     <= cib_nxt;
      rib_r     <= rib_nxt;
      bx_r      <= bx_nxt;
      pend_r    <= pend_nxt;
      b_valid_r <= accept && hit;
      fwd_r     <= b_valid_r && (b_addr_r == bx_r);
    end
    if (accept) begin
      b_addr_r  <= bx_r;
      b_first_r <= (cib_r == '0) && (rib_r == '0);
      b_last_r  <= cib_end && rib_end;
      b_img_r   <= last_x && last_y;
      b_s1_r    <= in_data.sample_first;
      b_s2_r    <= cfg.two_comp ? in_data.sample_second : '0;
    end
    fwd_data_r <= {hi_c, lo_c};
  end

  // line store: one entry per output column
  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      line_mem[b_addr_r] <= {hi_c, lo_c};
    end
    if (accept) begin
      rd_data_r <= line_mem[bx_r];
    end
  end

endmodule

@@ rtl/core/bxd_back.sv @@
// Back end: divides block sums by scale squared and holds the output beat.
// Depends on bxd_pkg and bxd_divu.
module bxd_back import bxd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_eff_t  cfg,
  input  logic      q_empty,
  input  blk_sum_t  q_data,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_beat_t out_data
);

  function automatic logic [PIX_W-1:0] sat8(input logic [SUM_W-1:0] v);
    return (|v[SUM_W-1:PIX_W]) ? {PIX_W{1'b1}} : v[PIX_W-1:0];
  endfunction

  bk_state_t        state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_r, res_r, res_c;
  logic             img_r;
  logic             s_one, out_free, pop_ok;
  logic             div_start, div_done;
  logic             res_ok, load_out, load_res;
  logic [DIV_W-1:0] div_sq;
  logic [SUM_W-1:0] quo1, quo2;

  assign s_one    = (cfg.scale == SCL_W'(1));
  assign div_sq   = DIV_W'(cfg.scale) * DIV_W'(cfg.scale);
  assign pop_ok   = out_pop && out_valid_r;
  assign out_free = !out_valid_r || pop_ok;

  bxd_divu #(.NW(SUM_W), .DW(DIV_W)) u_div_first (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (q_data.sum_first),
    .divisor   (div_sq),
    .busy      (),
    .done      (div_done),
    .quotient  (quo1),
    .remainder ()
  );

  bxd_divu #(.NW(SUM_W), .DW(DIV_W)) u_div_second (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (q_data.sum_second),
    .divisor   (div_sq),
    .busy      (),
    .done      (),
    .quotient  (quo2),
    .remainder ()
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (!s_one) begin
            state_nxt = BK_DIV;
          end else if (!out_free) begin
            state_nxt = BK_WAIT;
          end
        end
      end
      BK_DIV: begin
        if (div_done) begin
          state_nxt = out_free ? BK_IDLE : BK_WAIT;
        end
      end
      BK_WAIT: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    res_ok    = 1'b0;
    res_c     = '{average_first: sat8(quo1),
                  average_second: cfg.two_comp ? sat8(quo2) : '0,
                  image_last: img_r};
    case (state_r)
      BK_IDLE: begin
        q_pop     = !q_empty;
        div_start = !q_empty && !s_one;
        res_ok    = !q_empty && s_one;
        res_c     = '{average_first: sat8(q_data.sum_first),
                      average_second: cfg.two_comp ? sat8(q_data.sum_second) : '0,
                      image_last: q_data.img_last};
      end
      BK_DIV: begin
        res_ok = div_done;
      end
      BK_WAIT: begin
        res_ok = 1'b0;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  assign load_out = out_free && (res_ok || (state_r == BK_WAIT));
  assign load_res = res_ok && !out_free;
  assign out_valid_nxt = load_out ? 1'b1 : (pop_ok ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load_out) begin
      out_r <= (state_r == BK_WAIT) ? res_r : res_c;
    end
    if (load_res) begin
      res_r <= res_c;
    end
    if (div_start) begin
      img_r <= q_data.img_last;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/core/box_average_downscaler.sv @@
// Box average downscaler top level: config registers, front, queue, back.
// Depends on bxd_pkg, bxd_front, bxd_fifo, bxd_back.
//
// Usage:
//  - Config: write scale, source width, source height and the two-component flag
//    through cfg_wr_en/cfg_index/cfg_data while the block is idle. Out-of-range
//    values are clamped (zero reads as one). Writing the scale re-derives the
//    position within the current block from the pixel counters, with two 12-step
//    serial dividers; in_full is held high after such a write until they finish.
//  - Input: one source pixel per beat, raster order, taken on push && !full.
//    The front takes one beat per cycle unless full; line store read-modify-write
//    is pipelined with forwarding so consecutive pixels of one block never stall.
//  - Output: one averaged pixel per finished scale x scale block, oldest first,
//    shown while out_empty is low and taken on out_pop. image_last marks the last
//    output pixel of an image. Partial blocks at the right and bottom are dropped.
//  - Path: a closed block's sum passes the accumulate stage and the queue on its
//    way to the output register, and above scale 1 also the 16-step serial
//    divide by scale squared in the back. The back finishes one block per cycle
//    at scale 1 while the output is free, else one block per divide; a 4-entry
//    queue absorbs bursts, then in_full throttles input.
//  - Reset clears counters, queue and output register; config returns to scale 1,
//    1920 x 1080, luma only. The line store is not cleared (each block's first
//    pixel overwrites its entry). A stalled receiver backs up into in_full.
module box_average_downscaler import bxd_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_SCALE = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  output logic                  in_full,
  input  in_beat_t              in_data,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_beat_t             out_data
);

  localparam int WLIM = (MAX_WIDTH < 4095) ? MAX_WIDTH : 4095;
  localparam int SLIM = (MAX_SCALE < 31) ? MAX_SCALE : 31;
  localparam logic [DIM_W-1:0] WLIM_V = DIM_W'(WLIM);
  localparam logic [DIM_W-1:0] HLIM_V = DIM_W'(HGT_LIM);
  localparam logic [SCL_W-1:0] SLIM_V = SCL_W'(SLIM);

  logic [SCL_W-1:0] scale_r, scale_nxt;
  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic             two_comp_r, two_comp_nxt;
  logic             scale_wr;
  cfg_eff_t         cfg;

  logic             q_push, q_pop, q_empty;
  blk_sum_t         q_in, q_head;
  logic [QC_W-1:0]  q_count;

  // register writes
  always_comb begin
    scale_nxt    = scale_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    two_comp_nxt = two_comp_r;
    scale_wr     = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCALE: begin
          scale_nxt = cfg_data[SCL_W-1:0];
          scale_wr  = 1'b1;
        end
        CFG_WIDTH:    width_nxt    = cfg_data[DIM_W-1:0];
        CFG_HEIGHT:   height_nxt   = cfg_data[DIM_W-1:0];
        CFG_TWO_COMP: two_comp_nxt = cfg_data[0];
        default:      scale_wr     = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r    <= RST_SCALE;
      width_r    <= RST_WIDTH;
      height_r   <= RST_HEIGHT;
      two_comp_r <= 1'b0;
    end else begin
      scale_r    <= scale_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      two_comp_r <= two_comp_nxt;
    end
  end

  // clamp to the supported range
  always_comb begin
    cfg.scale    = (scale_r == '0) ? SCL_W'(1) :
                   (scale_r > SLIM_V) ? SLIM_V : scale_r;
    cfg.width    = (width_r == '0) ? DIM_W'(1) :
                   (width_r > WLIM_V) ? WLIM_V : width_r;
    cfg.height   = (height_r == '0) ? DIM_W'(1) :
                   (height_r > HLIM_V) ? HLIM_V : height_r;
    cfg.two_comp = two_comp_r;
  end

  bxd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .scale_wr (scale_wr),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  bxd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  bxd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/bxd_chk.sv @@
// Port-level checker for the box average downscaler, bound to the top level.
// Depends on bxd_pkg.
module bxd_chk import bxd_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_wr_en,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic                  in_full,
  input logic                  out_empty,
  input logic                  out_pop,
  input out_beat_t             out_data
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("result changed or vanished while waiting");

  // nothing left over from before reset
  a_rst_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty)
    else $error("result shown right after reset");

  a_rst_ready: assert property (@(posedge clk)
    $past(!rst_n) |-> !in_full)
    else $error("input blocked right after reset");

  // a scale write must hold off input while block positions are rederived
  a_scale_resync: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr_en && (cfg_index == CFG_SCALE)) |=> in_full)
    else $error("input taken during scale resync");

endmodule

bind box_average_downscaler bxd_chk u_bxd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .cfg_wr_en (cfg_wr_en),
  .cfg_index (cfg_index),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

@@ bench/box_average_downscaler_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for box_average_downscaler: directed and random pixel streams,
// every result beat compared with a behavioral box-average predictor.
// Depends on bxd_pkg and the box_average_downscaler RTL.
module box_average_downscaler_tb;
  import bxd_pkg::*;

  localparam int LINE_MAX     = 2048;  // line store depth and width clamp
  localparam int SCALE_MAX    = 16;
  localparam int SETTLE_CYC   = 40;    // covers the back-end divide
  localparam int TOTAL_BEATS  = 1350;  // input beats over the whole run

  // Pixel content patterns.
  typedef enum int {PX_RANDOM, PX_EXTREME, PX_FULL} px_mode_t;
  // Pacing of either side: no idling at all, or random gaps/stalls.
  typedef enum int {PACE_BURST, PACE_IDLING} pace_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  cfg_idx_t              cfg_index = CFG_SCALE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  in_beat_t              in_data = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  out_beat_t             out_data;

  always #5 clk = ~clk;

  box_average_downscaler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the registers, line store and counters.
  // ---------------------------------------------------------------------------
  logic [SCL_W-1:0] scale_reg;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic             two_comp_reg;
  logic [31:0]      line_sums [LINE_MAX];  // {second sum, first sum} per block column
  int unsigned      col_pos;
  int unsigned      row_pos;

  out_beat_t expected_avg [$];             // block means still owed by the DUT
  int        mismatches = 0;
  int        beats_sent = 0;

  pace_t     in_pace = PACE_IDLING;
  pace_t     pop_pace = PACE_IDLING;
  int        hold_request = 0;             // long receiver hold-off, in cycles
  int        pop_hold = 0;
  int        pop_stall = 0;

  function automatic int unsigned eff_scale();
    if (scale_reg == 0) return 1;
    if (scale_reg > SCALE_MAX) return SCALE_MAX;
    return scale_reg;
  endfunction

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Truncated mean; a sum left over from a larger scale can push it past 255.
  function automatic logic [PIX_W-1:0] block_mean(logic [SUM_W-1:0] sum, int unsigned s);
    int unsigned m;
    m = sum / (s * s);
    return (m > 255) ? 8'hFF : m[7:0];
  endfunction

  // Most gaps short, a few long; none at all in burst pacing.
  function automatic int pick_gap(pace_t pace);
    int r;
    if (pace == PACE_BURST) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [PIX_W-1:0] pick_sample(px_mode_t mode);
    case (mode)
      PX_RANDOM:  return PIX_W'($urandom_range(255));
      PX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
      default:    return 8'hFF;
    endcase
  endfunction

  // One accepted source pixel: accumulate into the line store, queue a mean
  // when it closes a block, then step the raster counters.
  function automatic void predict_pixel(in_beat_t px);
    int unsigned      s, w, h, nbx, nby, bx, by, cib, rib;
    logic [SUM_W-1:0] lo, hi, second;
    out_beat_t        mean_beat;
    s      = eff_scale();
    w      = clamp_dim(width_reg, LINE_MAX);
    h      = clamp_dim(height_reg, HGT_LIM);
    nbx    = w / s;
    nby    = h / s;
    second = two_comp_reg ? SUM_W'(px.sample_second) : '0;
    cib    = col_pos % s;
    rib    = row_pos % s;
    bx     = col_pos / s;
    by     = row_pos / s;
    if (bx < nbx && by < nby) begin
      if (cib == 0 && rib == 0) begin
        lo = SUM_W'(px.sample_first);
        hi = second;
      end else begin
        // 16-bit wrap per component is intended
        lo = line_sums[bx][15:0] + px.sample_first;
        hi = line_sums[bx][31:16] + second;
      end
      line_sums[bx] = {hi, lo};
      if (cib == s - 1 && rib == s - 1) begin
        mean_beat.average_first  = block_mean(lo, s);
        mean_beat.average_second = two_comp_reg ? block_mean(hi, s) : '0;
        mean_beat.image_last     = (bx == nbx - 1 && by == nby - 1);
        expected_avg.push_back(mean_beat);
      end
    end
    // counters past a shrunken size wrap on their next step
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: pop pacing on the falling edge, checking on the rising edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request > 0) begin
      pop_hold = hold_request;
      hold_request = 0;
    end
    if (pop_hold > 0) begin
      out_pop = 1'b0;
      pop_hold = pop_hold - 1;
    end else if (pop_stall > 0) begin
      out_pop = 1'b0;
      pop_stall = pop_stall - 1;
    end else begin
      pop_stall = pick_gap(pop_pace);
      out_pop = (pop_stall == 0);
      if (pop_stall > 0) pop_stall = pop_stall - 1;
    end
  end

  always @(posedge clk) begin : check_avg
    out_beat_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_avg.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none, got first %0d second %0d last %0b",
                 $time, out_data.average_first, out_data.average_second,
                 out_data.image_last);
      end else begin
        want = expected_avg.pop_front();
        if (out_data.average_first !== want.average_first) begin
          mismatches++;
          $display("%0t: average_first expected %0d, got %0d",
                   $time, want.average_first, out_data.average_first);
        end
        if (out_data.average_second !== want.average_second) begin
          mismatches++;
          $display("%0t: average_second expected %0d, got %0d",
                   $time, want.average_second, out_data.average_second);
        end
        if (out_data.image_last !== want.image_last) begin
          mismatches++;
          $display("%0t: image_last expected %0b, got %0b",
                   $time, want.image_last, out_data.image_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side helpers.
  // ---------------------------------------------------------------------------

  // Offer one pixel until it is taken; push stays high into the next call
  // when no gap follows, so back-to-back beats never drop push.
  task automatic send_pixel(logic [PIX_W-1:0] first, logic [PIX_W-1:0] second);
    int gap;
    @(negedge clk);
    in_push = 1'b1;
    in_data.sample_first = first;
    in_data.sample_second = second;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_pixel(in_data);
    beats_sent++;
    gap = pick_gap(in_pace);
    if (gap > 0) begin
      @(negedge clk);
      in_push = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop offering and wait for every owed result.
  task automatic drain_results();
    @(negedge clk);
    in_push = 1'b0;
    while (expected_avg.size() != 0) @(posedge clk);
  endtask

  // Idle point for register writes: a partial block may still be in flight
  // after the last owed result, so give it the pipeline latency as well.
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(val);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      CFG_SCALE:    scale_reg    = SCL_W'(val);
      CFG_WIDTH:    width_reg    = DIM_W'(val);
      CFG_HEIGHT:   height_reg   = DIM_W'(val);
      CFG_TWO_COMP: two_comp_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned s, int unsigned w, int unsigned h, int unsigned two);
    settle();
    write_reg(CFG_SCALE, s);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_TWO_COMP, two);
  endtask

  // Run the raster counters back to the image origin.
  task automatic finish_image(px_mode_t mode);
    while (col_pos != 0 || row_pos != 0)
      send_pixel(pick_sample(mode), pick_sample(mode));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset config: scale 1, 1920 x 1080, luma only; every pixel is its own
  // block and Cb must read back as zero.
  task automatic test_reset_values();
    send_pixel(8'h00, 8'hFF);
    send_pixel(8'hFF, 8'h00);
    repeat (4) send_pixel(pick_sample(PX_RANDOM), pick_sample(PX_RANDOM));
    drain_results();
  endtask

  // Height zero reads as one, so a single 16-pixel line ends the image.
  // Together with the reset test this sets line store entries 0 to 15, so
  // later register changes mid-image never read an unset entry.
  task automatic test_full_line();
    configure(1, 16, 0, 1);
    finish_image(PX_RANDOM);
    drain_results();
  endtask

  // Scale zero and width zero read as one; scale above 16 saturates; height
  // above 2048 saturates, then a shrunken height wraps the row counter.
  task automatic test_clamped_sizes();
    configure(0, 0, 3, 0);
    repeat (3) send_pixel(pick_sample(PX_RANDOM), pick_sample(PX_RANDOM));
    configure(31, 16, 12'hFFF, 1);
    repeat (256) send_pixel(pick_sample(PX_EXTREME), pick_sample(PX_RANDOM));
    settle();
    write_reg(CFG_HEIGHT, 16);  // row 16 is now past the bottom
    finish_image(PX_RANDOM);
    drain_results();
  endtask

  // Image smaller than one block: nothing ever comes out.
  task automatic test_small_image();
    configure(16, 8, 8, 1);
    repeat (64) send_pixel(pick_sample(PX_RANDOM), pick_sample(PX_RANDOM));
    configure(5, 4, 10, 0);
    repeat (40) send_pixel(pick_sample(PX_RANDOM), pick_sample(PX_RANDOM));
    settle();
  endtask

  // Register changes mid-image with all-white pixels: a large sum read back
  // at a smaller scale saturates the mean, a full 16x16 sum extended at
  // scale 3 wraps at 16 bits, then flag and width changes mid-row.
  task automatic test_midimage_changes();
    configure(16, 16, 40, 1);
    repeat (15 * 16) send_pixel(8'hFF, 8'hFF);
    settle();
    write_reg(CFG_SCALE, 2);
    repeat (16) send_pixel(8'hFF, 8'hFF);
    settle();
    write_reg(CFG_SCALE, 16);
    repeat (16 * 16) send_pixel(8'hFF, 8'hFF);
    settle();
    write_reg(CFG_SCALE, 3);
    repeat (16) send_pixel(8'hFF, 8'hFF);
    finish_image(PX_RANDOM);

    configure(1, 16, 4, 1);
    repeat (20) send_pixel(pick_sample(PX_RANDOM), pick_sample(PX_RANDOM));
    settle();
    write_reg(CFG_TWO_COMP, 0);
    repeat (3) send_pixel(pick_sample(PX_RANDOM), pick_sample(PX_RANDOM));
    settle();
    write_reg(CFG_WIDTH, 2);    // column counter now past the right edge
    finish_image(PX_RANDOM);
    drain_results();
  endtask

  // Receiver holds off while pixels keep coming, so the queue fills and
  // in_full stalls the input; then the sender waits for every result.
  task automatic test_backpressure();
    configure(1, 16, 8, 1);
    in_pace = PACE_BURST;
    @(posedge clk);
    hold_request = 200;
    repeat (128) send_pixel(pick_sample(PX_RANDOM), pick_sample(PX_RANDOM));
    drain_results();
    in_pace = PACE_IDLING;
  endtask

  // Random whole images under random settings until the beat budget is spent;
  // mostly small scales, a few large ones, some images smaller than a block,
  // the odd flag flip mid-image.
  task automatic test_random_images();
    int unsigned s_raw, s_eff, w, h, nimg, split, max_bx, max_by;
    int          r;
    px_mode_t    pm;
    while (beats_sent < TOTAL_BEATS) begin
      r = $urandom_range(99);
      if (r < 5) s_raw = 0;
      else if (r < 10) s_raw = $urandom_range(31, 17);
      else if (r < 22) s_raw = $urandom_range(16, 9);
      else s_raw = $urandom_range(8, 1);
      s_eff = (s_raw == 0) ? 1 : (s_raw > SCALE_MAX) ? SCALE_MAX : s_raw;

      if (s_eff > 8) begin
        w = s_eff + $urandom_range(2);
        h = s_eff + $urandom_range(2);
      end else begin
        max_bx = (s_eff < 3) ? 8 : (s_eff < 5) ? 4 : 2;
        max_by = (s_eff < 5) ? 3 : 2;
        w = s_eff * $urandom_range(max_bx, 1) + $urandom_range(s_eff - 1);
        h = s_eff * $urandom_range(max_by, 1) + $urandom_range(s_eff - 1);
      end
      if (s_eff > 1 && $urandom_range(9) == 0) w = $urandom_range(s_eff - 1, 1);

      configure(s_raw, w, h, $urandom_range(1));
      in_pace  = ($urandom_range(3) == 0) ? PACE_BURST : PACE_IDLING;
      pop_pace = ($urandom_range(3) == 0) ? PACE_BURST : PACE_IDLING;
      r  = $urandom_range(9);
      pm = (r < 7) ? PX_RANDOM : (r < 9) ? PX_EXTREME : PX_FULL;
      nimg  = (s_eff > 4) ? 1 : $urandom_range(3, 1);
      split = (w * h > 1 && $urandom_range(7) == 0) ? $urandom_range(w * h - 1, 1) : 0;

      for (int n = 0; n < nimg; n++) begin
        for (int p = 0; p < w * h; p++) begin
          if (n == 0 && split != 0 && p == split) begin
            settle();
            write_reg(CFG_TWO_COMP, !two_comp_reg);
          end
          send_pixel(pick_sample(pm), pick_sample(pm));
        end
      end
    end
    in_pace  = PACE_IDLING;
    pop_pace = PACE_IDLING;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------
  initial begin
    scale_reg    = RST_SCALE;
    width_reg    = RST_WIDTH;
    height_reg   = RST_HEIGHT;
    two_comp_reg = 1'b0;
    col_pos      = 0;
    row_pos      = 0;
    foreach (line_sums[i]) line_sums[i] = '0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_full_line();
    test_clamped_sizes();
    test_small_image();
    test_midimage_changes();
    test_backpressure();
    test_random_images();

    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hang guard, well above the slowest legal run.
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bxd_pkg.sv
rtl/core/bxd_divu.sv
rtl/core/bxd_fifo.sv
rtl/core/bxd_front.sv
rtl/core/bxd_back.sv
rtl/core/box_average_downscaler.sv
rtl/core/bxd_chk.sv
bench/box_average_downscaler_tb.sv
